@@ rtl/rmq_pkg.sv @@
package rmq_pkg;

  // Fixed-point constants of the Q1.14 format.
  localparam int unsigned ElemW   = 16;
  localparam int unsigned NumElem = 9;
  localparam int unsigned NumComp = 4;
  localparam int unsigned OneQ14  = 16384;
  localparam int unsigned OutMax  = 16384;

  // Pipeline depth: entry stage, one stage per root bit, divider set-up,
  // one stage per quotient bit.
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 15;
  localparam int unsigned NumStages = 1 + SqrtSteps + 1 + DivSteps;
  localparam int unsigned DivFirst  = 1 + SqrtSteps + 1;

  // Branch of Shepperd's method, named after the component taken from the root.
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

  // Payload carried through every pipeline stage.
  typedef struct packed {
    branch_e          br;
    logic [2:0][16:0] d;     // off-diagonal terms, signed, in output order
    logic [31:0]      rad;   // radicand, consumed two bits a step
    logic [17:0]      rem;   // square-root partial remainder
    logic [15:0]      root;  // square-root partial result
    logic [2:0][30:0] num;   // divider partial remainders
    logic [2:0]       neg;   // sign of each off-diagonal term
    logic [2:0]       ovf;   // quotient saturates regardless of low bits
    logic [2:0][14:0] quo;   // quotient bits
  } stage_t;

endpackage

@@ rtl/rotation_matrix_to_quaternion.sv @@
// The sqrt (one root bit per stage) and the three dividers (one quotient
// bit per stage) are fully pipelined; throughput is one matrix per cycle
// while the pipeline is not held.
// The whole pipeline holds while the output register is full and not taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; data is not reset.
module rotation_matrix_to_quaternion (
  input  logic         clk_i,
  input  logic         rst_ni,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (16 bits each, lowest first)
  input  logic [143:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // quat_w, quat_x, quat_y, quat_z (16 bits each, lowest first)
  output logic [63:0]  m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  localparam int unsigned NS = rmq_pkg::NumStages;

  logic                   en;
  logic [NS-1:0]          vld_q;
  rmq_pkg::stage_t        p_q   [NS];
  rmq_pkg::stage_t        p_d   [NS];
  logic                   out_vld_q;
  logic [63:0]            out_q;
  logic [63:0]            out_d;

  // The pipeline advances whenever the output register can take a value.
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // Entry stage: branch choice, square-root argument and off-diagonal terms.
  always_comb begin
    logic signed [15:0] r [rmq_pkg::NumElem];
    logic signed [18:0] tr;
    logic signed [18:0] arg;
    logic signed [16:0] dif_x, dif_y, dif_z, sum_xy, sum_xz, sum_yz;
    for (int i = 0; i < int'(rmq_pkg::NumElem); i++) begin
      r[i] = s_axis_tdata_i[i*rmq_pkg::ElemW +: rmq_pkg::ElemW];
    end
    tr     = 19'(r[0]) + 19'(r[4]) + 19'(r[8]);
    dif_x  = 17'(r[7]) - 17'(r[5]);
    dif_y  = 17'(r[2]) - 17'(r[6]);
    dif_z  = 17'(r[3]) - 17'(r[1]);
    sum_xy = 17'(r[1]) + 17'(r[3]);
    sum_xz = 17'(r[2]) + 17'(r[6]);
    sum_yz = 17'(r[5]) + 17'(r[7]);
    p_d[0] = '0;
    if (tr > 19'sd0) begin
      p_d[0].br = rmq_pkg::BR_TRACE;
      arg       = 19'(rmq_pkg::OneQ14) + tr;
      p_d[0].d  = {dif_z, dif_y, dif_x};
    end else if (r[0] > r[4] && r[0] > r[8]) begin
      p_d[0].br = rmq_pkg::BR_X;
      arg       = 19'(rmq_pkg::OneQ14) + 19'(r[0]) - 19'(r[4]) - 19'(r[8]);
      p_d[0].d  = {sum_xz, sum_xy, dif_x};
    end else if (r[4] > r[8]) begin
      p_d[0].br = rmq_pkg::BR_Y;
      arg       = 19'(rmq_pkg::OneQ14) + 19'(r[4]) - 19'(r[0]) - 19'(r[8]);
      p_d[0].d  = {sum_yz, sum_xy, dif_y};
    end else begin
      p_d[0].br = rmq_pkg::BR_Z;
      arg       = 19'(rmq_pkg::OneQ14) + 19'(r[8]) - 19'(r[0]) - 19'(r[4]);
      p_d[0].d  = {sum_yz, sum_xz, dif_z};
    end
    // Clamp so that the root never falls below 128.
    if (arg < 19'sd1) begin
      arg = 19'sd1;
    end
    p_d[0].rad = {1'b0, arg[16:0], 14'd0};
  end

  // Square root, one result bit per stage.
  for (genvar k = 1; k <= int'(rmq_pkg::SqrtSteps); k++) begin : g_sqrt
    always_comb begin
      logic [19:0] rem_n;
      logic [19:0] trial;
      p_d[k] = p_q[k-1];
      rem_n  = {p_q[k-1].rem, p_q[k-1].rad[31:30]};
      trial  = {2'b00, p_q[k-1].root, 2'b01};
      p_d[k].rad = {p_q[k-1].rad[29:0], 2'b00};
      if (rem_n >= trial) begin
        p_d[k].rem  = 18'(rem_n - trial);
        p_d[k].root = {p_q[k-1].root[14:0], 1'b1};
      end else begin
        p_d[k].rem  = rem_n[17:0];
        p_d[k].root = {p_q[k-1].root[14:0], 1'b0};
      end
    end
  end

  // Divider set-up: magnitudes, rounding offset and early saturation.
  always_comb begin
    localparam int unsigned S = rmq_pkg::SqrtSteps + 1;
    logic [16:0] mag;
    logic [30:0] num;
    logic [31:0] lim;
    p_d[S] = p_q[S-1];
    lim    = {p_q[S-1].root, 1'b0, 15'd0};
    for (int j = 0; j < 3; j++) begin
      p_d[S].neg[j] = p_q[S-1].d[j][16];
      mag = p_q[S-1].d[j][16] ? 17'(-p_q[S-1].d[j]) : p_q[S-1].d[j];
      num = {mag, 14'd0} + 31'(p_q[S-1].root);
      p_d[S].num[j] = num;
      p_d[S].ovf[j] = {1'b0, num} >= lim;
      p_d[S].quo[j] = '0;
    end
  end

  // Restoring division by twice the root, one quotient bit per stage.
  for (genvar k = rmq_pkg::DivFirst; k < NS; k++) begin : g_div
    localparam int unsigned Bit = NS - 1 - k;
    always_comb begin
      logic [31:0] sub;
      p_d[k] = p_q[k-1];
      sub    = 32'({p_q[k-1].root, 1'b0}) << Bit;
      for (int j = 0; j < 3; j++) begin
        if ({1'b0, p_q[k-1].num[j]} >= sub) begin
          p_d[k].num[j]      = 31'({1'b0, p_q[k-1].num[j]} - sub);
          p_d[k].quo[j][Bit] = 1'b1;
        end
      end
    end
  end

  // Output formatting: signs, saturation and placement by branch.
  always_comb begin
    logic [16:0]       half;
    logic [2:0][15:0]  lane;
    logic [15:0]       hq;
    logic [15:0]       mq;
    half = (17'(p_q[NS-1].root) + 17'd1) >> 1;
    hq   = (half > 17'(rmq_pkg::OutMax)) ? 16'(rmq_pkg::OutMax) : half[15:0];
    for (int j = 0; j < 3; j++) begin
      if (p_q[NS-1].ovf[j] || p_q[NS-1].quo[j] > 15'(rmq_pkg::OutMax)) begin
        mq = 16'(rmq_pkg::OutMax);
      end else begin
        mq = {1'b0, p_q[NS-1].quo[j]};
      end
      lane[j] = p_q[NS-1].neg[j] ? 16'(-mq) : mq;
    end
    case (p_q[NS-1].br)
      rmq_pkg::BR_TRACE: out_d = {lane[2], lane[1], lane[0], hq};
      rmq_pkg::BR_X:     out_d = {lane[2], lane[1], hq, lane[0]};
      rmq_pkg::BR_Y:     out_d = {lane[2], hq, lane[1], lane[0]};
      rmq_pkg::BR_Z:     out_d = {hq, lane[2], lane[1], lane[0]};
      default:           out_d = '0;
    endcase
  end

  // Valid bits travel with the data and are the only reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NS-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[NS-1];
    end
  end

  // Stage payload registers.
  for (genvar k = 0; k < NS; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[k] <= p_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

@@ sim/tb_rotation_matrix_to_quaternion.sv @@
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;

  localparam int unsigned LatencyCycles = 34;
  localparam int unsigned NumRandom     = 1500;
  localparam longint      CycleLimit    = 2000000;

  typedef logic signed [15:0] q14_t;
  typedef q14_t matrix_t [9];

  // Quaternion in output order w, x, y, z.
  typedef struct packed {
    q14_t w;
    q14_t x;
    q14_t y;
    q14_t z;
  } quat_t;

  int unsigned num_errors = 0;

  // Prints one line per mismatch and keeps the count.
  task automatic report_mismatch(input string what);
    num_errors++;
    $display("ERROR %0t: %s", $realtime, what);
  endtask

  // Bit-exact conversion of one matrix into its quaternion.
  class quat_scoreboard;
    quat_t pending[$];

    static function longint clamp_q14(input longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
    endfunction

    static function longint int_sqrt(input longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    endfunction

    // Rounded to nearest, ties away from zero.
    static function longint scaled_div(input longint d, input longint root);
      longint den, mag, q;
      den = 2 * root;
      mag = (d < 0) ? -d : d;
      q   = (mag * 16384 + den / 2) / den;
      return clamp_q14((d < 0) ? -q : q);
    endfunction

    static function quat_t convert(input matrix_t m);
      longint a[9];
      longint trace, arg, root, half;
      longint qw, qx, qy, qz;
      rmq_pkg::branch_e br;
      quat_t   q;
      foreach (a[i]) a[i] = m[i];
      trace = a[0] + a[4] + a[8];
      if (trace > 0) begin
        br  = rmq_pkg::BR_TRACE;
        arg = 16384 + trace;
      end else if (a[0] > a[4] && a[0] > a[8]) begin
        br  = rmq_pkg::BR_X;
        arg = 16384 + a[0] - a[4] - a[8];
      end else if (a[4] > a[8]) begin
        br  = rmq_pkg::BR_Y;
        arg = 16384 + a[4] - a[0] - a[8];
      end else begin
        br  = rmq_pkg::BR_Z;
        arg = 16384 + a[8] - a[0] - a[4];
      end
      if (arg < 1) arg = 1;
      root = int_sqrt(arg * 16384);
      half = clamp_q14((root + 1) >>> 1);
      case (br)
        rmq_pkg::BR_TRACE: begin
          qw = half;
          qx = scaled_div(a[7] - a[5], root);
          qy = scaled_div(a[2] - a[6], root);
          qz = scaled_div(a[3] - a[1], root);
        end
        rmq_pkg::BR_X: begin
          qw = scaled_div(a[7] - a[5], root);
          qx = half;
          qy = scaled_div(a[1] + a[3], root);
          qz = scaled_div(a[2] + a[6], root);
        end
        rmq_pkg::BR_Y: begin
          qw = scaled_div(a[2] - a[6], root);
          qx = scaled_div(a[1] + a[3], root);
          qy = half;
          qz = scaled_div(a[5] + a[7], root);
        end
        default: begin
          qw = scaled_div(a[3] - a[1], root);
          qx = scaled_div(a[2] + a[6], root);
          qy = scaled_div(a[5] + a[7], root);
          qz = half;
        end
      endcase
      q.w = qw[15:0];
      q.x = qx[15:0];
      q.y = qy[15:0];
      q.z = qz[15:0];
      return q;
    endfunction

    function void note_input(input matrix_t m);
      pending.push_back(convert(m));
    endfunction

    task check_result(input logic [63:0] data);
      quat_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected quaternion %h", data));
        return;
      end
      want = pending.pop_front();
      if (data[15:0] !== want.w)
        report_mismatch($sformatf("w got %0d want %0d", $signed(data[15:0]), want.w));
      if (data[31:16] !== want.x)
        report_mismatch($sformatf("x got %0d want %0d", $signed(data[31:16]), want.x));
      if (data[47:32] !== want.y)
        report_mismatch($sformatf("y got %0d want %0d", $signed(data[47:32]), want.y));
      if (data[63:48] !== want.z)
        report_mismatch($sformatf("z got %0d want %0d", $signed(data[63:48]), want.z));
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic [143:0] s_axis_tdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [63:0]  m_axis_tdata_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;

  quat_scoreboard quat_sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_receiver  = 1'b0;
  longint      cycle_count    = 0;

  rotation_matrix_to_quaternion i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_rotation_matrix_to_quaternion NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold when requested.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready_i <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every output transfer is checked.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) quat_sb.check_result(m_axis_tdata_o);
  end

  // Offers one matrix and waits for its transfer, idling at random beforehand.
  task automatic send_matrix(input matrix_t m);
    logic [143:0] flat;
    foreach (m[i]) flat[16*i +: 16] = m[i];
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= flat;
    do @(posedge clk_i); while (!s_axis_tready_o);
    quat_sb.note_input(m);
  endtask

  task automatic finish_burst();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (quat_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Near-orthonormal matrix from a random quaternion, with some noise.
  function automatic matrix_t random_rotation();
    real w, x, y, z, n;
    real r[9];
    matrix_t m;
    w = $urandom_range(2000) / 1000.0 - 1.0;
    x = $urandom_range(2000) / 1000.0 - 1.0;
    y = $urandom_range(2000) / 1000.0 - 1.0;
    z = $urandom_range(2000) / 1000.0 - 1.0;
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 0.01) begin
      w = 1.0;
      n = 1.0;
    end
    w /= n; x /= n; y /= n; z /= n;
    r[0] = 1 - 2 * (y * y + z * z); r[1] = 2 * (x * y - w * z); r[2] = 2 * (x * z + w * y);
    r[3] = 2 * (x * y + w * z); r[4] = 1 - 2 * (x * x + z * z); r[5] = 2 * (y * z - w * x);
    r[6] = 2 * (x * z - w * y); r[7] = 2 * (y * z + w * x); r[8] = 1 - 2 * (x * x + y * y);
    foreach (m[i]) begin
      int v;
      v = $rtoi(r[i] * 16384.0) + $signed($urandom_range(8)) - 4;
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      m[i] = q14_t'(v);
    end
    return m;
  endfunction

  function automatic matrix_t random_matrix(input bit full_range);
    matrix_t m;
    foreach (m[i]) m[i] = full_range ? q14_t'($urandom()) : q14_t'($urandom_range(32768) - 16384);
    return m;
  endfunction

  function automatic matrix_t diag(input int a, input int b, input int c);
    matrix_t m;
    foreach (m[i]) m[i] = '0;
    m[0] = q14_t'(a);
    m[4] = q14_t'(b);
    m[8] = q14_t'(c);
    return m;
  endfunction

  // Directed cases: identity, each branch, branch ties, clamped root, extremes.
  task automatic run_directed();
    matrix_t m;
    send_matrix(diag(16384, 16384, 16384));
    send_matrix(diag(16384, -16384, -16384));
    send_matrix(diag(-16384, 16384, -16384));
    send_matrix(diag(-16384, -16384, 16384));
    send_matrix(diag(0, 0, 0));
    send_matrix(diag(-8192, -8192, -8192));
    send_matrix(diag(-16384, -16384, -16384));
    send_matrix(diag(-5000, -5000, -5000));
    send_matrix(diag(0, 0, -1));
    send_matrix(diag(1, 1, -2));
    send_matrix(diag(-16384, 0, 0));
    send_matrix(diag(-32768, -32768, -32768));
    send_matrix(diag(32767, 32767, 32767));
    send_matrix(diag(32767, -32768, -32768));
    send_matrix(diag(-32768, 32767, -32768));
    m = diag(-32768, -32768, 32767);
    m[1] = 16'sh7fff; m[3] = 16'sh7fff; m[2] = 16'sh8000; m[6] = 16'sh8000;
    send_matrix(m);
    m = diag(16384, 0, 0);
    m[5] = 16'sh4000; m[7] = 16'shc000;
    send_matrix(m);
    foreach (m[i]) m[i] = 16'h7fff;
    send_matrix(m);
    foreach (m[i]) m[i] = 16'h8000;
    send_matrix(m);
    foreach (m[i]) m[i] = 16'hffff;
    send_matrix(m);
    foreach (m[i]) m[i] = (i % 2) ? 16'h5555 : 16'haaaa;
    send_matrix(m);
    foreach (m[i]) m[i] = (i % 2) ? 16'haaaa : 16'h5555;
    send_matrix(m);
    finish_burst();
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned sel;
    for (int unsigned k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 60) send_matrix(random_rotation());
      else if (sel < 85) send_matrix(random_matrix(1'b0));
      else send_matrix(random_matrix(1'b1));
    end
    finish_burst();
  endtask

  // Receiver holds for a long stretch while the sender keeps offering.
  initial begin
    wait (hold_receiver);
    repeat (200) @(posedge clk_i);
    hold_receiver = 1'b0;
  end

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    rst_ni          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Phases of idling on each side.
    run_random(NumRandom / 5);
    send_idle_pct = 82;
    run_random(NumRandom / 5);
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    run_random(NumRandom / 5);
    send_idle_pct = 32;
    recv_stall_pct = 32;
    run_random(NumRandom / 5);

    // Sender pauses until the pipeline has drained.
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_receiver  = 1'b1;
    run_random(NumRandom / 5);

    wait_drained();
    repeat (LatencyCycles + 10) @(posedge clk_i);
    if (num_errors == 0) begin
      $display("tb_rotation_matrix_to_quaternion OK");
    end else begin
      $display("tb_rotation_matrix_to_quaternion NOT OK");
    end
    $finish;
  end

endmodule
